// File: rtl/dmv_pkg.sv
// Shared definitions for the diagonal matrix-vector product block.
// Holds field widths, register indexes, action codes, the sequencer state
// type and the structs that pass between the sequencer and the datapath.
package dmv_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_DIM_DEFAULT    = 64;
    localparam int COEF_WIDTH_DEFAULT = 16;

    // Fixed field widths of the input and result beats.
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int OUT_INDEX_W = 6;
    localparam int RES_W       = 40;

    // Configuration registers.
    localparam int DIM_W       = 7;
    localparam int TOL_W       = 31;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 1;

    localparam logic [DIM_W-1:0]       DIM_RESET     = 7'd64;
    localparam logic [TOL_W-1:0]       TOL_RESET     = '0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIMENSION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 1'b1;

    // What an input beat asks for.
    typedef enum logic [1:0] {
        ACT_LOAD_MATRIX = 2'd0,
        ACT_LOAD_VECTOR = 2'd1,
        ACT_COMPUTE     = 2'd2
    } action_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_MAC,
        ST_ERROR
    } seq_state_t;

    // Control bits that travel with each memory read through the datapath.
    // In the scan pass first/last mark the ends of a diagonal and start marks
    // the first read of the run; in the product pass first/last mark the ends
    // of a row and run_end marks the last read of the run.
    typedef struct packed {
        logic valid;
        logic scan;
        logic start;
        logic first;
        logic last;
        logic run_end;
    } tag_t;

    // Write strobes for the two stores.
    typedef struct packed {
        logic mat_we;
        logic vec_we;
    } load_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic advance;
        logic busy;
        logic any_active;
    } dp_status_t;

endpackage

// File: rtl/diagonal_matrix_vector_product.sv
// Load beats (matrix or vector entry) are taken one per cycle while idle.
// A compute beat makes n*n reads to find active diagonals, drains the pipeline,
// then makes n*n product reads, one matrix entry per cycle through the single
// matrix read port unless the result stalls; with no active diagonal it gives
// one no-terms beat. Reset sets dimension 64 and tolerance 0 and empties the
// pipeline; the stores are not cleared and hold nothing valid until loaded.
module diagonal_matrix_vector_product #(
    parameter int MAX_DIM    = dmv_pkg::MAX_DIM_DEFAULT,
    parameter int COEF_WIDTH = dmv_pkg::COEF_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input beat.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata from bit 0: row, column, value_re, value_im, zero padding.
    input  logic [((dmv_pkg::ROW_W + dmv_pkg::COL_W + 2 * COEF_WIDTH + 7) / 8) * 8 - 1:0]
                                                s_tdata,
    // tuser: action.
    input  logic [1:0]                          s_tuser,
    // Result beat.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata from bit 0: index, result_re, result_im, zero padding.
    output logic [((dmv_pkg::OUT_INDEX_W + 2 * dmv_pkg::RES_W + 7) / 8) * 8 - 1:0]
                                                m_tdata,
    // tuser: no_terms.
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [dmv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dmv_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dmv_pkg::*;

    localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int C          = COEF_WIDTH;
    localparam int OUT_DATA_W = ((OUT_INDEX_W + 2 * RES_W + 7) / 8) * 8;
    localparam int RE_LSB     = ROW_W + COL_W;

    logic [DIM_W-1:0]        dimension_reg;
    logic [TOL_W-1:0]        tolerance_reg;

    logic [ROW_W-1:0]        in_row;
    logic [COL_W-1:0]        in_column;
    logic [2*C-1:0]          in_entry;
    action_t                 in_action;

    load_t                   load;
    dp_status_t              status;
    tag_t                    issue;
    logic [ADDR_W-1:0]       wr_addr_mat;
    logic [IDX_W-1:0]        wr_addr_vec;
    logic [ADDR_W-1:0]       rd_addr_mat;
    logic [IDX_W-1:0]        rd_addr_vec;
    logic [IDX_W-1:0]        issue_row;
    logic [IDX_W-1:0]        issue_diag;
    logic                    emit_error;
    logic [2*C-1:0]          rd_mat;
    logic [2*C-1:0]          rd_vec;

    logic [OUT_INDEX_W-1:0]  out_index;
    logic signed [RES_W-1:0] out_re;
    logic signed [RES_W-1:0] out_im;
    logic                    out_no_terms;

    // Input beat fields; entries are stored with im above re.
    assign in_row    = s_tdata[ROW_W-1:0];
    assign in_column = s_tdata[RE_LSB-1:ROW_W];
    assign in_entry  = {s_tdata[RE_LSB+2*C-1:RE_LSB+C], s_tdata[RE_LSB+C-1:RE_LSB]};
    assign in_action = action_t'(s_tuser);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIM_RESET;
            tolerance_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIMENSION: dimension_reg <= cfg_data[DIM_W-1:0];
                CFG_TOLERANCE: tolerance_reg <= cfg_data[TOL_W-1:0];
                default:
                begin
                    dimension_reg <= dimension_reg;
                end
            endcase
        end
    end

    dmv_seq #(
        .MAX_DIM(MAX_DIM)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (in_action),
        .in_row     (in_row),
        .in_column  (in_column),
        .dimension  (dimension_reg),
        .status     (status),
        .load       (load),
        .wr_addr_mat(wr_addr_mat),
        .wr_addr_vec(wr_addr_vec),
        .rd_addr_mat(rd_addr_mat),
        .rd_addr_vec(rd_addr_vec),
        .issue      (issue),
        .issue_row  (issue_row),
        .issue_diag (issue_diag),
        .emit_error (emit_error)
    );

    dmv_store #(
        .MAX_DIM   (MAX_DIM),
        .COEF_WIDTH(COEF_WIDTH)
    ) u_store (
        .clk        (clk),
        .load       (load),
        .wr_addr_mat(wr_addr_mat),
        .wr_addr_vec(wr_addr_vec),
        .wr_data    (in_entry),
        .advance    (status.advance),
        .rd_addr_mat(rd_addr_mat),
        .rd_addr_vec(rd_addr_vec),
        .rd_mat     (rd_mat),
        .rd_vec     (rd_vec)
    );

    dmv_datapath #(
        .MAX_DIM   (MAX_DIM),
        .COEF_WIDTH(COEF_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .tolerance   (tolerance_reg),
        .issue       (issue),
        .issue_row   (issue_row),
        .issue_diag  (issue_diag),
        .emit_error  (emit_error),
        .rd_mat      (rd_mat),
        .rd_vec      (rd_vec),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_index   (out_index),
        .out_re      (out_re),
        .out_im      (out_im),
        .out_no_terms(out_no_terms),
        .out_last    (m_tlast)
    );

    // Result beat packing.
    assign m_tdata = {{(OUT_DATA_W - OUT_INDEX_W - 2 * RES_W){1'b0}}, out_im, out_re, out_index};
    assign m_tuser = out_no_terms;

endmodule

// File: rtl/dmv_store.sv
// Matrix and vector stores: synchronous memories with one write port for
// loads and one registered read port for the sequencer.
// Depends on dmv_pkg for the load strobe struct and default sizes.
module dmv_store #(
    parameter int MAX_DIM    = dmv_pkg::MAX_DIM_DEFAULT,
    parameter int COEF_WIDTH = dmv_pkg::COEF_WIDTH_DEFAULT,
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic                    clk,
    input  dmv_pkg::load_t          load,
    input  logic [ADDR_W-1:0]       wr_addr_mat,
    input  logic [IDX_W-1:0]        wr_addr_vec,
    input  logic [2*COEF_WIDTH-1:0] wr_data,
    input  logic                    advance,
    input  logic [ADDR_W-1:0]       rd_addr_mat,
    input  logic [IDX_W-1:0]        rd_addr_vec,
    output logic [2*COEF_WIDTH-1:0] rd_mat,
    output logic [2*COEF_WIDTH-1:0] rd_vec
);
    import dmv_pkg::*;

    localparam int ENTRY_W = 2 * COEF_WIDTH;

    // Entries hold re in the low half and im in the high half.
    logic [ENTRY_W-1:0] matrix_mem [MAX_DIM * MAX_DIM];
    logic [ENTRY_W-1:0] vector_mem [MAX_DIM];

    // Matrix store: load writes, read data held while the datapath stalls.
    always_ff @(posedge clk)
    begin
        if (load.mat_we)
        begin
            matrix_mem[wr_addr_mat] <= wr_data;
        end
        if (advance)
        begin
            rd_mat <= matrix_mem[rd_addr_mat];
        end
    end

    // Vector store, same arrangement.
    always_ff @(posedge clk)
    begin
        if (load.vec_we)
        begin
            vector_mem[wr_addr_vec] <= wr_data;
        end
        if (advance)
        begin
            rd_vec <= vector_mem[rd_addr_vec];
        end
    end

endmodule

// File: rtl/dmv_seq.sv
// Sequencer: takes input beats, decodes loads, and for a compute walks the
// matrix to find active diagonals, then, if any is active, row by row.
// Depends on dmv_pkg for the action codes, state type and structs.
module dmv_seq #(
    parameter int MAX_DIM = dmv_pkg::MAX_DIM_DEFAULT,
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  dmv_pkg::action_t          in_action,
    input  logic [dmv_pkg::ROW_W-1:0] in_row,
    input  logic [dmv_pkg::COL_W-1:0] in_column,
    input  logic [dmv_pkg::DIM_W-1:0] dimension,
    input  dmv_pkg::dp_status_t       status,
    output dmv_pkg::load_t            load,
    output logic [ADDR_W-1:0]         wr_addr_mat,
    output logic [IDX_W-1:0]          wr_addr_vec,
    output logic [ADDR_W-1:0]         rd_addr_mat,
    output logic [IDX_W-1:0]          rd_addr_vec,
    output dmv_pkg::tag_t             issue,
    output logic [IDX_W-1:0]          issue_row,
    output logic [IDX_W-1:0]          issue_diag,
    output logic                      emit_error
);
    import dmv_pkg::*;

    localparam int NW = IDX_W + 1;

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [NW-1:0]    n_use;
    logic [NW-1:0]    n_m1;
    logic             accept;
    logic             start_compute;
    logic             last_i;
    logic             last_r;
    logic [IDX_W-1:0] c_inc;

    // Size in use: zero counts as one, anything above the store size is clamped.
    always_comb
    begin
        if (dimension == '0)
        begin
            n_use = NW'(1);
        end
        else if (dimension > MAX_DIM)
        begin
            n_use = NW'(MAX_DIM);
        end
        else
        begin
            n_use = NW'(dimension);
        end
    end

    assign n_m1 = n_use - NW'(1);

    // Loads write straight into the stores; out-of-store indexes are dropped.
    assign accept        = in_valid && in_ready;
    assign start_compute = accept && (in_action == ACT_COMPUTE);
    assign load.mat_we   = accept && (in_action == ACT_LOAD_MATRIX)
                           && (in_row < MAX_DIM) && (in_column < MAX_DIM);
    assign load.vec_we   = accept && (in_action == ACT_LOAD_VECTOR) && (in_row < MAX_DIM);
    assign wr_addr_mat   = ADDR_W'(in_row * MAX_DIM + in_column);
    assign wr_addr_vec   = IDX_W'(in_row);

    // Walk position: column wraps modulo n.
    assign last_i = (NW'(i_reg) == n_m1);
    assign last_r = (NW'(r_reg) == n_m1);
    assign c_inc  = (NW'(c_reg) == n_m1) ? '0 : c_reg + IDX_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_compute)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.advance && last_i && last_r)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:
            begin
                // Diagonal flags are all written once the pipeline is empty.
                if (!status.busy)
                begin
                    state_next = status.any_active ? ST_MAC : ST_ERROR;
                end
            end
            ST_MAC:
            begin
                if (status.advance && last_i && last_r)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (status.advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Counter updates. The scan pass runs diagonal by diagonal, the product
    // pass row by row with the rotation as the inner index.
    always_comb
    begin
        r_next = r_reg;
        i_next = i_reg;
        c_next = c_reg;
        case (state_reg)
            ST_SCAN:
            begin
                if (status.advance)
                begin
                    if (last_i)
                    begin
                        i_next = '0;
                        r_next = r_reg + IDX_W'(1);
                        c_next = r_reg + IDX_W'(1);
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                        c_next = c_inc;
                    end
                end
            end
            ST_MAC:
            begin
                if (status.advance)
                begin
                    if (last_r)
                    begin
                        r_next = '0;
                        i_next = i_reg + IDX_W'(1);
                        c_next = i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        r_next = r_reg + IDX_W'(1);
                        c_next = c_inc;
                    end
                end
            end
            default:
            begin
                r_next = '0;
                i_next = '0;
                c_next = '0;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        emit_error    = (state_reg == ST_ERROR);
        issue.valid   = (state_reg == ST_SCAN) || (state_reg == ST_MAC);
        issue.scan    = (state_reg == ST_SCAN);
        issue.start   = (state_reg == ST_SCAN) && (r_reg == '0) && (i_reg == '0);
        issue.first   = (state_reg == ST_SCAN) ? (i_reg == '0) : (r_reg == '0);
        issue.last    = (state_reg == ST_SCAN) ? last_i : last_r;
        issue.run_end = (state_reg == ST_MAC) && last_i && last_r;
        issue_row     = i_reg;
        issue_diag    = r_reg;
        rd_addr_mat   = ADDR_W'(i_reg * MAX_DIM + c_reg);
        rd_addr_vec   = c_reg;
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            i_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            i_reg     <= i_next;
            c_reg     <= c_next;
        end
    end

endmodule

// File: rtl/dmv_datapath.sv
// Datapath: shared complex multiplier, diagonal activity detection with its
// flag memory, row accumulation, saturation and the result register.
// Depends on dmv_pkg for widths and the tag and status structs.
module dmv_datapath #(
    parameter int MAX_DIM    = dmv_pkg::MAX_DIM_DEFAULT,
    parameter int COEF_WIDTH = dmv_pkg::COEF_WIDTH_DEFAULT,
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [dmv_pkg::TOL_W-1:0]              tolerance,
    input  dmv_pkg::tag_t                          issue,
    input  logic [IDX_W-1:0]                       issue_row,
    input  logic [IDX_W-1:0]                       issue_diag,
    input  logic                                   emit_error,
    input  logic [2*COEF_WIDTH-1:0]                rd_mat,
    input  logic [2*COEF_WIDTH-1:0]                rd_vec,
    output dmv_pkg::dp_status_t                    status,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [dmv_pkg::OUT_INDEX_W-1:0]        out_index,
    output logic signed [dmv_pkg::RES_W-1:0]       out_re,
    output logic signed [dmv_pkg::RES_W-1:0]       out_im,
    output logic                                   out_no_terms,
    output logic                                   out_last
);
    import dmv_pkg::*;

    localparam int C      = COEF_WIDTH;
    localparam int PROD_W = 2 * C;
    localparam int TERM_W = 2 * C + 1;
    localparam int ACC_W  = TERM_W + IDX_W + 1;
    localparam int CMP_W  = (PROD_W > TOL_W) ? PROD_W : TOL_W;

    logic advance;

    // Stage D: memory data arrives with its tag.
    tag_t             d_tag_reg;
    logic [IDX_W-1:0] d_row_reg;
    logic [IDX_W-1:0] d_diag_reg;
    logic             flag_q_reg;
    logic             flag_mem [MAX_DIM];

    // Stage P: products.
    tag_t                     p_tag_reg;
    logic [IDX_W-1:0]         p_row_reg;
    logic [IDX_W-1:0]         p_diag_reg;
    logic                     p_act_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;

    // Stage S: sums of products and the tolerance compare.
    tag_t                     s_tag_reg;
    logic [IDX_W-1:0]         s_row_reg;
    logic [IDX_W-1:0]         s_diag_reg;
    logic                     s_hit_reg;
    logic signed [TERM_W-1:0] s_re_reg, s_im_reg;

    // Stage A: accumulation and diagonal flags.
    logic                     run_reg;
    logic                     run_next;
    logic                     any_reg;
    logic                     flag_we;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]  acc_re_next, acc_im_next;
    logic signed [ACC_W-1:0]  acc_re_base, acc_im_base;
    logic                     fin_valid_reg;
    logic                     fin_end_reg;
    logic [IDX_W-1:0]         fin_row_reg;
    logic signed [ACC_W-1:0]  fin_re_reg, fin_im_reg;
    logic signed [RES_W-1:0]  sat_re, sat_im;

    logic signed [C-1:0]      ar, ai, xr, xi;
    logic signed [C-1:0]      mul0_b, mul1_b;
    logic [PROD_W-1:0]        mag;
    logic                     hit;
    logic signed [TERM_W-1:0] term_re, term_im;

    // The whole pipeline moves when the result register is free or draining.
    assign advance = !out_valid || out_ready;

    assign status.advance    = advance;
    assign status.busy       = d_tag_reg.valid || p_tag_reg.valid || s_tag_reg.valid
                               || fin_valid_reg;
    assign status.any_active = any_reg;

    // Flag memory: read for the product pass, written at the end of each
    // diagonal of the scan pass. The sequencer drains between the two.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flag_q_reg <= flag_mem[issue_diag];
            if (flag_we)
            begin
                flag_mem[s_diag_reg] <= run_next;
            end
        end
    end

    // Operand split and multiplier sharing: the scan pass squares the entry.
    assign ar     = rd_mat[C-1:0];
    assign ai     = rd_mat[2*C-1:C];
    assign xr     = rd_vec[C-1:0];
    assign xi     = rd_vec[2*C-1:C];
    assign mul0_b = d_tag_reg.scan ? ar : xr;
    assign mul1_b = d_tag_reg.scan ? ai : xi;

    // Squared magnitude against tolerance, and the complex product terms.
    assign mag     = p0_reg[PROD_W-1:0] + p1_reg[PROD_W-1:0];
    assign hit     = CMP_W'(mag) > CMP_W'(tolerance);
    assign term_re = p_act_reg ? (TERM_W'(p0_reg) - TERM_W'(p1_reg)) : '0;
    assign term_im = p_act_reg ? (TERM_W'(p2_reg) + TERM_W'(p3_reg)) : '0;

    // Activity of the current diagonal and the row accumulators.
    assign run_next    = (s_tag_reg.first ? 1'b0 : run_reg) | s_hit_reg;
    assign flag_we     = s_tag_reg.valid && s_tag_reg.scan && s_tag_reg.last;
    assign acc_re_base = s_tag_reg.first ? '0 : acc_re_reg;
    assign acc_im_base = s_tag_reg.first ? '0 : acc_im_reg;
    assign acc_re_next = acc_re_base + ACC_W'(s_re_reg);
    assign acc_im_next = acc_im_base + ACC_W'(s_im_reg);

    // Tag valid bits and the control registers of stage A.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_tag_reg     <= '0;
            p_tag_reg     <= '0;
            s_tag_reg     <= '0;
            fin_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
            any_reg       <= 1'b0;
            out_valid     <= 1'b0;
        end
        else if (advance)
        begin
            d_tag_reg     <= issue;
            p_tag_reg     <= d_tag_reg;
            s_tag_reg     <= p_tag_reg;
            fin_valid_reg <= s_tag_reg.valid && !s_tag_reg.scan && s_tag_reg.last;
            if (s_tag_reg.valid && s_tag_reg.scan)
            begin
                run_reg <= run_next;
                any_reg <= (s_tag_reg.start ? 1'b0 : any_reg)
                           | (s_tag_reg.last & run_next);
            end
            out_valid     <= fin_valid_reg || emit_error;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_row_reg  <= issue_row;
            d_diag_reg <= issue_diag;

            p_row_reg  <= d_row_reg;
            p_diag_reg <= d_diag_reg;
            p_act_reg  <= flag_q_reg;
            p0_reg     <= ar * mul0_b;
            p1_reg     <= ai * mul1_b;
            p2_reg     <= ar * xi;
            p3_reg     <= ai * xr;

            s_row_reg  <= p_row_reg;
            s_diag_reg <= p_diag_reg;
            s_hit_reg  <= hit;
            s_re_reg   <= term_re;
            s_im_reg   <= term_im;

            if (s_tag_reg.valid && !s_tag_reg.scan)
            begin
                acc_re_reg <= acc_re_next;
                acc_im_reg <= acc_im_next;
                if (s_tag_reg.last)
                begin
                    fin_re_reg  <= acc_re_next;
                    fin_im_reg  <= acc_im_next;
                    fin_row_reg <= s_row_reg;
                    fin_end_reg <= s_tag_reg.run_end;
                end
            end
        end
    end

    // Saturation to the result width, needed only when the sum can exceed it.
    generate
        if (ACC_W > RES_W)
        begin : g_sat
            logic fits_re, fits_im;

            assign fits_re = (fin_re_reg[ACC_W-1:RES_W-1] == '0)
                             || (fin_re_reg[ACC_W-1:RES_W-1] == '1);
            assign fits_im = (fin_im_reg[ACC_W-1:RES_W-1] == '0)
                             || (fin_im_reg[ACC_W-1:RES_W-1] == '1);
            assign sat_re  = fits_re ? fin_re_reg[RES_W-1:0]
                             : {fin_re_reg[ACC_W-1], {(RES_W-1){~fin_re_reg[ACC_W-1]}}};
            assign sat_im  = fits_im ? fin_im_reg[RES_W-1:0]
                             : {fin_im_reg[ACC_W-1], {(RES_W-1){~fin_im_reg[ACC_W-1]}}};
        end
        else
        begin : g_ext
            assign sat_re = RES_W'(fin_re_reg);
            assign sat_im = RES_W'(fin_im_reg);
        end
    endgenerate

    // Result register: a finished row, or the single no-terms beat.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (fin_valid_reg)
            begin
                out_index    <= OUT_INDEX_W'(fin_row_reg);
                out_re       <= sat_re;
                out_im       <= sat_im;
                out_no_terms <= 1'b0;
                out_last     <= fin_end_reg;
            end
            else
            begin
                out_index    <= '0;
                out_re       <= '0;
                out_im       <= '0;
                out_no_terms <= 1'b1;
                out_last     <= 1'b1;
            end
        end
    end

endmodule
